@@ hdl/rsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsm_pkg
// shared types and constants of the range match table and its list parser
// ----------------------------------------------------------------------------
package rsm_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // characters of the range list syntax
  localparam logic [7:0] CHAR_MARK  = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_DASH  = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // append request from the parser
  typedef struct packed {
    logic        req;
    logic [31:0] lo;
    logic [31:0] hi;
  } app_req_t;

endpackage

@@ hdl/rsm_parser.sv @@
// ----------------------------------------------------------------------------
// rsm_parser
// character-at-a-time parser of range lists such as "X5 X7-12"
// ----------------------------------------------------------------------------
module rsm_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        text_char,
  input  logic              text_last,
  output rsm_pkg::app_req_t app
);
  import rsm_pkg::*;

  typedef enum logic [4:0] {
    PH_SEEK_MARK = 5'b00001,
    PH_SEEK_LOW  = 5'b00010,
    PH_LOW       = 5'b00100,
    PH_SEEK_HIGH = 5'b01000,
    PH_HIGH      = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] low_accum, low_accum_next;
  logic [31:0] high_accum, high_accum_next;

  logic        is_digit;
  logic [31:0] digit;
  logic        is_mark;
  phase_t      after_token;

  assign is_digit    = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
  assign digit       = {28'd0, text_char[3:0]};
  assign is_mark     = (text_char == CHAR_MARK);
  assign after_token = is_mark ? PH_SEEK_LOW : PH_SEEK_MARK;

  always_comb begin
    phase_next      = phase;
    low_accum_next  = low_accum;
    high_accum_next = high_accum;
    app             = '0;
    if (text_char != CHAR_NUL) begin
      case (phase)
        PH_SEEK_LOW: begin
          if (is_digit) begin
            low_accum_next = digit;
            phase_next     = PH_LOW;
          end
        end
        PH_LOW: begin
          if (is_digit) begin
            // times ten as two shifts and an add
            low_accum_next = (low_accum << 3) + (low_accum << 1) + digit;
          end else if (text_char == CHAR_DASH) begin
            phase_next = PH_SEEK_HIGH;
          end else begin
            app        = '{req: 1'b1, lo: low_accum, hi: low_accum};
            phase_next = after_token;
          end
        end
        PH_SEEK_HIGH: begin
          if (is_digit) begin
            high_accum_next = digit;
            phase_next      = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (is_digit) begin
            high_accum_next = (high_accum << 3) + (high_accum << 1) + digit;
          end else begin
            app        = '{req: 1'b1, lo: low_accum, hi: high_accum};
            phase_next = after_token;
          end
        end
        default: begin
          phase_next = after_token;
        end
      endcase
    end
    // end of text closes a pending number
    if (text_last || (text_char == CHAR_NUL)) begin
      if (phase_next == PH_LOW) begin
        app = '{req: 1'b1, lo: low_accum_next, hi: low_accum_next};
      end else if (phase_next == PH_HIGH) begin
        app = '{req: 1'b1, lo: low_accum_next, hi: high_accum_next};
      end
      phase_next = PH_SEEK_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEEK_MARK;
      low_accum  <= '0;
      high_accum <= '0;
    end else if (step) begin
      phase      <= phase_next;
      low_accum  <= low_accum_next;
      high_accum <= high_accum_next;
    end
  end

endmodule

@@ hdl/rsm_table.sv @@
// ----------------------------------------------------------------------------
// rsm_table
// range storage with one registered read port and the shared comparator pair
// ----------------------------------------------------------------------------
module rsm_table #(
  parameter int SLOTS = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_lo,
  input  logic [31:0]   wr_hi,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [31:0]   probe_value,
  output logic          rd_valid,
  output logic          match
);
  import rsm_pkg::*;

  logic [63:0] mem [SLOTS-1];
  logic [63:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_hi, wr_lo};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // inclusive bounds check on the entry just read
  assign match = (probe_value >= rd_data[31:0]) && (probe_value <= rd_data[63:32]);

endmodule

@@ hdl/range_set_match_with_list_parser_unit.sv @@
// add and text transactions go from the execute state to the done state, where the result is registered
// query: one stored range compared per cycle in the scan state, early exit on a hit
// the scan rate is set by the single read port of the range memory and one comparator pair
// one transaction is in work at a time; the next is taken once the result is registered
// synchronous active-high reset empties the table and puts the parser back to seeking 'X'
// ----------------------------------------------------------------------------
// range_set_match_with_list_parser_unit
// range match table with add, query and streaming range-list text commands
// ----------------------------------------------------------------------------
module range_set_match_with_list_parser_unit #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // range_low[31:0], range_high[63:32],
                                  // probe_value[95:64], text_char[103:96]
  input  logic [1:0]   s_tuser,   // command[1:0]
  input  logic         s_tlast,   // text_last
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata    // hit[0], range_added[1], dropped_full[2],
                                  // stored_count[6:3], zero[7]
);
  import rsm_pkg::*;

  // count holds 0..SLOTS-1, address reaches SLOTS-2
  localparam int CW = $clog2(SLOTS);
  localparam int AW = (SLOTS > 2) ? $clog2(SLOTS - 1) : 1;
  localparam logic [CW-1:0] MAX_COUNT = CW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched transaction
  logic [1:0]  command;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [31:0] probe_value;
  logic [7:0]  text_char;
  logic        text_last;

  // table bookkeeping and result flags
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          hit, added, dropped;

  app_req_t      parse_app;
  app_req_t      app;
  logic          room;
  logic          tbl_wr_en;
  logic          tbl_rd_en;
  logic          rd_valid;
  logic          match;
  logic          out_free;
  logic [CW+3:0] count_ext;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign room     = (count < MAX_COUNT);

  // payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      command     <= s_tuser;
      range_low   <= s_tdata[31:0];
      range_high  <= s_tdata[63:32];
      probe_value <= s_tdata[95:64];
      text_char   <= s_tdata[103:96];
      text_last   <= s_tlast;
    end
  end

  rsm_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      ((state == S_EXEC) && (command == CMD_TEXT)),
    .text_char (text_char),
    .text_last (text_last),
    .app       (parse_app)
  );

  // append request from an add command or a finished text token
  always_comb begin
    app = '0;
    case (command)
      CMD_ADD:   app = '{req: 1'b1, lo: range_low, hi: range_high};
      CMD_TEXT:  app = parse_app;
      CMD_QUERY: app = '0;
      CMD_NONE:  app = '0;
      default:   app = '0;
    endcase
  end

  assign tbl_wr_en = (state == S_EXEC) && app.req && room;
  assign tbl_rd_en = (state == S_SCAN) && (scan_idx < count);

  rsm_table #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (tbl_wr_en),
    .wr_addr     (count[AW-1:0]),
    .wr_lo       (app.lo),
    .wr_hi       (app.hi),
    .rd_en       (tbl_rd_en),
    .rd_addr     (scan_idx[AW-1:0]),
    .probe_value (probe_value),
    .rd_valid    (rd_valid),
    .match       (match)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (command == CMD_QUERY) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // stop on the first hit, or once every issued read has been compared
        if ((rd_valid && match) || (!rd_valid && (scan_idx == count))) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_idx <= '0;
      hit      <= 1'b0;
      added    <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        scan_idx <= '0;
        hit      <= 1'b0;
        added    <= app.req && room;
        dropped  <= app.req && !room;
        if (tbl_wr_en) begin
          count <= count + 1'b1;
        end
      end
      if (tbl_rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if ((state == S_SCAN) && rd_valid && match) begin
        hit <= 1'b1;
      end
    end
  end

  // output register: the result waits here while the next transaction is taken
  assign count_ext = {4'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {1'b0, count_ext[3:0], dropped, added, hit};
    end
  end

`ifndef ASSERT_OFF
  // the table never holds more than its capacity
  assert property (@(posedge clk) disable iff (rst) count <= MAX_COUNT)
    else $error("range count beyond capacity");

  // a table write bumps the count by exactly one
  assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |=> (count == $past(count) + 1'b1))
    else $error("count did not follow table write");

  // the scan never reads past the stored ranges
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= count))
    else $error("scan index past range count");

  // writes only come from the execute step
  assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> ((state == S_EXEC) && (command != CMD_QUERY)))
    else $error("table write outside execute step");
`endif

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream bench for the range match table: a short directed walk, then random
// add, query and range-list text traffic, each result checked against its typed-in
// value or a behavioral copy of the table and its list parser
// ----------------------------------------------------------------------------
module tb_top;
  import rsm_pkg::*;

  // the table holds SLOTS-1 ranges with the default parameter
  localparam int          TABLE_DEPTH  = 15;
  localparam int          DIRECTED_MAX = 25;
  localparam int          RANDOM_ITEMS = 1025;
  localparam int          TOTAL_ITEMS  = DIRECTED_MAX + RANDOM_ITEMS;
  // idle time at the end of the run, after the last result has come back
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // one input transaction, unpacked from the stream fields
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] range_lo;
    logic [31:0] range_hi;
    logic [31:0] probe;
    logic [7:0]  ch;
    logic        last;
  } range_cmd_t;

  // one result transaction
  typedef struct packed {
    logic       hit;
    logic       added;
    logic       dropped;
    logic [3:0] count;
  } match_status_t;

  // a directed step, with its result typed in where it is obvious
  typedef struct packed {
    range_cmd_t    item;
    logic          known;
    match_status_t want;
  } plan_row_t;

  // list parser phases
  typedef enum logic [2:0] {
    SEEK_MARK,
    SEEK_LOW,
    IN_LOW,
    SEEK_HIGH,
    IN_HIGH
  } list_phase_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;   // range_low[31:0], range_high[63:32],
                                // probe_value[95:64], text_char[103:96]
  logic [1:0]   s_tuser = CMD_NONE;  // command[1:0]
  logic         s_tlast = 1'b0; // text_last
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;        // hit[0], range_added[1], dropped_full[2],
                                // stored_count[6:3], zero[7]

  // shadow copy of the table and the parser
  logic [31:0]   lo_tab [TABLE_DEPTH];
  logic [31:0]   hi_tab [TABLE_DEPTH];
  int unsigned   tab_fill = 0;
  list_phase_t   list_phase = SEEK_MARK;
  logic [31:0]   low_acc = '0;
  logic [31:0]   high_acc = '0;

  match_status_t pending_status [$];
  plan_row_t     plan_rows [$];
  int unsigned   items_sent = 0;
  int unsigned   errors = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   rcv_idle_pct = 0;

  range_set_match_with_list_parser_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_status.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioral table and parser
  // ---------------------------------------------------------------------------

  // append when a slot is free, otherwise flag the drop
  task automatic store_range(input logic [31:0] lo, input logic [31:0] hi,
                             inout match_status_t r);
    if (tab_fill < TABLE_DEPTH) begin
      lo_tab[tab_fill] = lo;
      hi_tab[tab_fill] = hi;
      tab_fill++;
      r.added = 1'b1;
    end else begin
      r.dropped = 1'b1;
    end
  endtask

  task automatic predict_status(input range_cmd_t t, output match_status_t r);
    logic        is_dig;
    logic [31:0] dv;
    r = '0;
    is_dig = (t.ch >= CHAR_ZERO) && (t.ch <= CHAR_NINE);
    dv = {24'd0, t.ch - CHAR_ZERO};
    case (t.cmd)
      CMD_ADD: begin
        store_range(t.range_lo, t.range_hi, r);
      end
      CMD_QUERY: begin
        // first stored range holding the probe wins
        for (int i = 0; i < tab_fill; i++) begin
          if (!r.hit && t.probe >= lo_tab[i] && t.probe <= hi_tab[i]) r.hit = 1'b1;
        end
      end
      CMD_TEXT: begin
        // a nul character carries no content, it only ends the text
        if (t.ch != CHAR_NUL) begin
          case (list_phase)
            SEEK_LOW: begin
              if (is_dig) begin
                low_acc = dv;
                list_phase = IN_LOW;
              end
            end
            IN_LOW: begin
              if (is_dig) begin
                low_acc = low_acc * 32'd10 + dv;
              end else if (t.ch == CHAR_DASH) begin
                list_phase = SEEK_HIGH;
              end else begin
                // single value, then the same character may open a new token
                store_range(low_acc, low_acc, r);
                list_phase = (t.ch == CHAR_MARK) ? SEEK_LOW : SEEK_MARK;
              end
            end
            SEEK_HIGH: begin
              if (is_dig) begin
                high_acc = dv;
                list_phase = IN_HIGH;
              end
            end
            IN_HIGH: begin
              if (is_dig) begin
                high_acc = high_acc * 32'd10 + dv;
              end else begin
                store_range(low_acc, high_acc, r);
                list_phase = (t.ch == CHAR_MARK) ? SEEK_LOW : SEEK_MARK;
              end
            end
            default: begin
              list_phase = (t.ch == CHAR_MARK) ? SEEK_LOW : SEEK_MARK;
            end
          endcase
        end
        // end of text flushes a number in progress
        if (t.last || t.ch == CHAR_NUL) begin
          if (list_phase == IN_LOW) store_range(low_acc, low_acc, r);
          else if (list_phase == IN_HIGH) store_range(low_acc, high_acc, r);
          list_phase = SEEK_MARK;
        end
      end
      default: ;
    endcase
    r.count = tab_fill[3:0];
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // random content in every field, so unused fields toggle too
  function automatic range_cmd_t random_cmd(input logic [1:0] cmd);
    range_cmd_t t;
    t.cmd      = cmd;
    t.range_lo = $urandom;
    t.range_hi = $urandom;
    t.probe    = $urandom;
    t.ch       = 8'($urandom_range(255));
    t.last     = 1'($urandom_range(1));
    return t;
  endfunction

  // drive one transaction, wait for the handshake, then queue its result
  task automatic send_cmd(input range_cmd_t t, input logic known, input match_status_t want);
    int unsigned   gap;
    match_status_t got;
    // idle mix follows the position in the run
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 38;
      rcv_idle_pct  = 58;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 58;
      rcv_idle_pct  = 38;
    end else begin
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
    end
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t.ch, t.probe, t.range_hi, t.range_lo};
    s_tuser  <= t.cmd;
    s_tlast  <= t.last;
    do @(posedge clk); while (!s_tready);
    predict_status(t, got);
    pending_status.push_back(known ? want : got);
    if (t.cmd != CMD_NONE) items_sent++;
  endtask

  task automatic send_text(input logic [7:0] ch, input logic last);
    range_cmd_t t;
    t      = random_cmd(CMD_TEXT);
    t.ch   = ch;
    t.last = last;
    send_cmd(t, 1'b0, '0);
  endtask

  task automatic send_digits(input int unsigned n, input logic last_on_final);
    for (int i = 0; i < n; i++) begin
      send_text(CHAR_ZERO + 8'($urandom_range(9)), last_on_final && (i == n - 1));
    end
  endtask

  // any nonzero character that is not a digit
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    case ($urandom_range(4))
      0: c = 8'h20;
      1: c = 8'h2c;
      2: c = CHAR_DASH;
      3: c = CHAR_MARK;
      default: begin
        do c = 8'($urandom_range(255, 1)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      end
    endcase
    return c;
  endfunction

  // mostly short numbers, now and then long enough to wrap
  function automatic int unsigned digit_count();
    return ($urandom_range(9) == 0) ? $urandom_range(11, 8) : $urandom_range(4, 1);
  endfunction

  // one well-formed token "X<low>[-<high>]" with random content and endings
  task automatic send_range_token();
    int unsigned ending;
    logic        has_high;
    if ($urandom_range(3) == 0) send_text(filler_char(), 1'b0);
    send_text(CHAR_MARK, 1'b0);
    if ($urandom_range(4) == 0) send_text(filler_char(), 1'b0);
    has_high = ($urandom_range(2) != 0);
    ending   = $urandom_range(9);
    send_digits(digit_count(), !has_high && ending == 0);
    if (has_high) begin
      send_text(CHAR_DASH, 1'b0);
      if ($urandom_range(4) == 0) send_text(filler_char(), 1'b0);
      send_digits(digit_count(), ending == 0);
    end
    // separator, separator marked last, or nul; a last digit already ended it
    if (ending == 1) send_text(filler_char(), 1'b1);
    else if (ending == 2) send_text(CHAR_NUL, 1'(ending == 2 && $urandom_range(1)));
    else if (ending != 0) send_text(filler_char(), 1'b0);
  endtask

  task automatic send_query();
    range_cmd_t  t;
    int unsigned k;
    t = random_cmd(CMD_QUERY);
    if (tab_fill != 0 && $urandom_range(3) != 0) begin
      // probe on or just beside a stored bound
      k = $urandom_range(tab_fill - 1);
      t.probe = $urandom_range(1) ? lo_tab[k] : hi_tab[k];
      t.probe = t.probe + 32'($urandom_range(2)) - 32'd1;
    end else if ($urandom_range(3) == 0) begin
      t.probe = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
    end
    send_cmd(t, 1'b0, '0);
  endtask

  task automatic send_add();
    range_cmd_t t;
    t = random_cmd(CMD_ADD);
    case ($urandom_range(4))
      0: begin
        t.range_lo = $urandom_range(20000);
        t.range_hi = t.range_lo;
      end
      1: begin
        t.range_lo = $urandom_range(20000);
        t.range_hi = t.range_lo + $urandom_range(500);
      end
      2: begin
        // wide span, may wrap into an empty range
        t.range_hi = t.range_lo + $urandom_range(32'h00ff_ffff);
      end
      3: begin
        if ($urandom_range(1)) begin
          t.range_lo = 32'h0;
          t.range_hi = $urandom_range(1000);
        end else begin
          t.range_lo = 32'hffff_ffff - $urandom_range(1000);
          t.range_hi = 32'hffff_ffff;
        end
      end
      default: ;  // fully random, often inverted
    endcase
    send_cmd(t, 1'b0, '0);
  endtask

  // directed step builder
  task automatic plan(input logic [1:0] cmd, input logic [31:0] lo, input logic [31:0] hi,
                      input logic [31:0] probe, input logic [7:0] ch, input logic last,
                      input logic known, input match_status_t want);
    plan_row_t row;
    row.item  = '{cmd, lo, hi, probe, ch, last};
    row.known = known;
    row.want  = want;
    plan_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    string       wrap_num;
    int unsigned pick;
    wrap_num = "4294967306";  // 2^32 + 10, accumulates to 10

    // empty table, unused command, bound extremes
    plan(CMD_QUERY, '1, '1, '0, 8'hff, 1'b1, 1'b1, {1'b0, 1'b0, 1'b0, 4'd0});
    plan(CMD_NONE, '1, '0, '1, CHAR_MARK, 1'b1, 1'b1, {1'b0, 1'b0, 1'b0, 4'd0});
    plan(CMD_ADD, '0, '0, '1, 8'h00, 1'b0, 1'b1, {1'b0, 1'b1, 1'b0, 4'd1});
    plan(CMD_ADD, '1, '1, '0, 8'hff, 1'b1, 1'b1, {1'b0, 1'b1, 1'b0, 4'd2});
    plan(CMD_QUERY, '0, '0, '1, 8'h00, 1'b0, 1'b1, {1'b1, 1'b0, 1'b0, 4'd2});
    plan(CMD_QUERY, '1, '1, 32'd1, 8'hff, 1'b1, 1'b1, {1'b0, 1'b0, 1'b0, 4'd2});
    // "X3-X7X9" then nul: the marker is skipped while seeking the high
    // digit, the marker after the high digits ends the range and opens a
    // new token, and nul ends the text with a pending low bound
    plan(CMD_TEXT, '0, '0, '0, CHAR_MARK, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '1, '1, '1, 8'h33, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '0, '0, '0, CHAR_DASH, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '1, '1, '1, CHAR_MARK, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '0, '0, '0, 8'h37, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '1, '1, '1, CHAR_MARK, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '0, '0, '0, CHAR_NINE, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '1, '1, '1, CHAR_NUL, 1'b0, 1'b0, '0);
    // wrapping number ended by the last flag on its final digit
    plan(CMD_TEXT, '0, '0, '0, CHAR_MARK, 1'b0, 1'b0, '0);
    plan(CMD_TEXT, '1, '1, '1, 8'hff, 1'b0, 1'b0, '0);
    for (int i = 0; i < wrap_num.len(); i++) begin
      plan(CMD_TEXT, '0, '1, '0, wrap_num[i], 1'(i == wrap_num.len() - 1), 1'b0, '0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) send_cmd(plan_rows[i].item, plan_rows[i].known, plan_rows[i].want);

    // random traffic; the table fills early and later appends are dropped
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30) send_query();
      else if (pick < 45) send_add();
      else if (pick < 85) send_range_token();
      else if (pick < 95) send_text(8'($urandom_range(255)), 1'($urandom_range(7) == 0));
      else send_cmd(random_cmd(CMD_NONE), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    match_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_status.pop_front();
        compare_field("hit", {3'd0, want.hit}, {3'd0, m_tdata[0]});
        compare_field("range_added", {3'd0, want.added}, {3'd0, m_tdata[1]});
        compare_field("dropped_full", {3'd0, want.dropped}, {3'd0, m_tdata[2]});
        compare_field("stored_count", want.count, m_tdata[6:3]);
        compare_field("pad bit", 4'd0, {3'd0, m_tdata[7]});
      end
    end
    // stall pattern follows the current idle mix
    m_tready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
  end

endmodule
